// ===== rtl/core/sni_pkg.sv =====
// Shared constants and types for the sensor noise injector.
// Holds the hash constants, channel salts, register indexes and the channel control struct.
// No dependencies.
`default_nettype none

package sni_pkg;

    localparam int NUM_CH     = 8;
    localparam int CH_STAGES  = 7;    // stages inside one channel (pipeline stages 3..9)
    localparam int NUM_STAGES = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int AMP_W      = 31;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam logic [15:0] SALT_GPS_X    = 16'h4101;
    localparam logic [15:0] SALT_GPS_Y    = 16'h4102;
    localparam logic [15:0] SALT_GPS_Z    = 16'h4103;
    localparam logic [15:0] SALT_IMU_YAW  = 16'h4201;
    localparam logic [15:0] SALT_IMU_PIT  = 16'h4202;
    localparam logic [15:0] SALT_IMU_ROLL = 16'h4203;
    localparam logic [15:0] SALT_BARO     = 16'h4301;
    localparam logic [15:0] SALT_MAG      = 16'h4401;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GPS_BIAS     = 3'd0,
        CFG_GPS_NOISE    = 3'd1,
        CFG_IMU_YAW_BIAS = 3'd2,
        CFG_IMU_NOISE    = 3'd3,
        CFG_BARO_BIAS    = 3'd4,
        CFG_BARO_NOISE   = 3'd5,
        CFG_MAG_BIAS     = 3'd6,
        CFG_MAG_NOISE    = 3'd7
    } cfg_idx_t;

    // Per-stage load enables for one channel, lowest bit is the first channel stage.
    typedef struct packed {
        logic [CH_STAGES-1:0] en;
    } ch_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sni_channel.sv =====
// One noise channel: salt mix, two split 64-bit hash multiplies, scale and saturating add.
// Seven payload stages; load enables come from the top level. Uses sni_pkg.
`default_nettype none

module sni_channel (
    input  wire                        aclk,
    input  sni_pkg::ch_ctrl_t          ctrl,
    input  wire  [63:0]                mix_in,     // seed ^ (step * golden)
    input  wire  [15:0]                salt,
    input  wire  signed [32:0]         base,       // true value plus bias
    input  wire  [sni_pkg::AMP_W-1:0]  amp,
    output logic signed [31:0]         result
);
    import sni_pkg::*;

    logic signed [32:0] base3_reg, base4_reg, base5_reg, base6_reg, base7_reg, base8_reg;
    logic [63:0]        z1_reg, z2_reg;
    logic [63:0]        a_ll_reg, b_ll_reg;
    logic [31:0]        a_lh_reg, a_hl_reg, b_lh_reg, b_hl_reg;
    logic signed [16:0] n_reg;
    logic signed [47:0] p_reg;
    logic signed [31:0] result_reg;

    logic [63:0]        z_next, z1_next, y_next, z2_next, y2_next, h_next;
    logic [63:0]        a_ll_next, b_ll_next;
    logic [31:0]        a_lh_next, a_hl_next, b_lh_next, b_hl_next;
    logic signed [47:0] n_ext, amp_ext, p_next;
    logic signed [31:0] noise;
    logic signed [33:0] sum;
    logic signed [31:0] result_next;

    always_comb begin
        z_next  = (mix_in ^ {48'd0, salt}) + GOLDEN_GAMMA;
        z1_next = z_next ^ (z_next >> 30);

        a_ll_next = {32'd0, z1_reg[31:0]} * {32'd0, MIX_MUL_A[31:0]};
        a_lh_next = z1_reg[31:0] * MIX_MUL_A[63:32];
        a_hl_next = z1_reg[63:32] * MIX_MUL_A[31:0];

        y_next  = a_ll_reg + {a_lh_reg + a_hl_reg, 32'd0};
        z2_next = y_next ^ (y_next >> 27);

        b_ll_next = {32'd0, z2_reg[31:0]} * {32'd0, MIX_MUL_B[31:0]};
        b_lh_next = z2_reg[31:0] * MIX_MUL_B[63:32];
        b_hl_next = z2_reg[63:32] * MIX_MUL_B[31:0];

        y2_next = b_ll_reg + {b_lh_reg + b_hl_reg, 32'd0};
        h_next  = y2_next ^ (y2_next >> 31);

        // top 17 hash bits less 65536: the msb inverted gives the signed value
        n_ext   = 48'(n_reg);
        amp_ext = $signed({17'd0, amp});
        p_next  = n_ext * amp_ext;

        // floor shift of the product, always fits 32 signed bits
        noise = p_reg[47:16];
        sum   = 34'(base8_reg) + 34'(noise);
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            result_next = sum[31:0];
        end else if (sum[33]) begin
            result_next = 32'sh8000_0000;
        end else begin
            result_next = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            z1_reg    <= z1_next;
            base3_reg <= base;
        end
        if (ctrl.en[1]) begin
            a_ll_reg  <= a_ll_next;
            a_lh_reg  <= a_lh_next;
            a_hl_reg  <= a_hl_next;
            base4_reg <= base3_reg;
        end
        if (ctrl.en[2]) begin
            z2_reg    <= z2_next;
            base5_reg <= base4_reg;
        end
        if (ctrl.en[3]) begin
            b_ll_reg  <= b_ll_next;
            b_lh_reg  <= b_lh_next;
            b_hl_reg  <= b_hl_next;
            base6_reg <= base5_reg;
        end
        if (ctrl.en[4]) begin
            n_reg     <= $signed({~h_next[63], h_next[62:47]});
            base7_reg <= base6_reg;
        end
        if (ctrl.en[5]) begin
            p_reg     <= p_next;
            base8_reg <= base7_reg;
        end
        if (ctrl.en[6]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sensor_noise_injector.sv =====
// Top level of the sensor noise injector: stream ports, configuration registers,
// shared step hash stages and eight noise channels. Uses sni_pkg and sni_channel.
//
// Usage:
//   s_ channel carries one true vehicle state a request (position, attitude, seed, step);
//   m_ channel returns the eight noisy sensor readings for it, in order.
//   A request is taken when tvalid and tready are both high at a rising aclk edge.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata, one register
//   per cycle, while no request is in flight.
// Throughput: one request per cycle while m_tready is high; the pipeline is nine
//   register stages (two for the step multiply, seven per channel for the hash
//   multiplies, scale and add), each multiply split into 32x32 partial products
//   and summed in the next stage.
// Stall: each stage holds while it is full and the one after cannot take its data,
//   so empty stages still fill while m_tready is low; nothing is lost or repeated.
// Reset: aresetn low at a clock edge empties the pipeline and clears all
//   configuration registers to zero.
`default_nettype none

module sensor_noise_injector (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration
    input  wire                                cfg_wr_en,
    input  wire  [sni_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [sni_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, yaw, pitch, roll (32 each), noise_seed, step_index (64 each)
    input  wire  [319:0]                       s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // gps_x, gps_y, gps_z, imu_yaw, imu_pitch, imu_roll, baro_alt, mag_heading (32 each)
    output logic [255:0]                       m_tdata
);
    import sni_pkg::*;

    logic signed [31:0] gps_bias_reg, imu_yaw_bias_reg, baro_bias_reg, mag_bias_reg;
    logic [AMP_W-1:0]   gps_noise_reg, imu_noise_reg, baro_noise_reg, mag_noise_reg;

    logic [NUM_STAGES:1]   valid_reg, valid_next;
    logic [NUM_STAGES+1:1] en;

    logic [63:0]        seed1_reg, pp_ll_reg, mix2_reg;
    logic [31:0]        pp_lh_reg, pp_hl_reg;
    logic signed [32:0] base1_reg [NUM_CH];
    logic signed [32:0] base2_reg [NUM_CH];

    logic signed [31:0] true_val [NUM_CH];
    logic signed [31:0] bias_val [NUM_CH];
    logic [AMP_W-1:0]   amp_val  [NUM_CH];
    logic [15:0]        salt_val [NUM_CH];
    logic signed [31:0] ch_result [NUM_CH];
    logic [63:0]        step_in, seed_in;
    logic [63:0]        pp_ll_next, mix2_next;
    logic [31:0]        pp_lh_next, pp_hl_next;
    ch_ctrl_t           ch_ctrl;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gps_bias_reg     <= '0;
            gps_noise_reg    <= '0;
            imu_yaw_bias_reg <= '0;
            imu_noise_reg    <= '0;
            baro_bias_reg    <= '0;
            baro_noise_reg   <= '0;
            mag_bias_reg     <= '0;
            mag_noise_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GPS_BIAS:     gps_bias_reg     <= cfg_wdata;
                CFG_GPS_NOISE:    gps_noise_reg    <= cfg_wdata[AMP_W-1:0];
                CFG_IMU_YAW_BIAS: imu_yaw_bias_reg <= cfg_wdata;
                CFG_IMU_NOISE:    imu_noise_reg    <= cfg_wdata[AMP_W-1:0];
                CFG_BARO_BIAS:    baro_bias_reg    <= cfg_wdata;
                CFG_BARO_NOISE:   baro_noise_reg   <= cfg_wdata[AMP_W-1:0];
                CFG_MAG_BIAS:     mag_bias_reg     <= cfg_wdata;
                CFG_MAG_NOISE:    mag_noise_reg    <= cfg_wdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // channel routing; baro uses y as the up axis, mag uses yaw
    always_comb begin
        true_val[0] = s_tdata[31:0];
        true_val[1] = s_tdata[63:32];
        true_val[2] = s_tdata[95:64];
        true_val[3] = s_tdata[127:96];
        true_val[4] = s_tdata[159:128];
        true_val[5] = s_tdata[191:160];
        true_val[6] = s_tdata[63:32];
        true_val[7] = s_tdata[127:96];

        bias_val[0] = gps_bias_reg;
        bias_val[1] = gps_bias_reg;
        bias_val[2] = gps_bias_reg;
        bias_val[3] = imu_yaw_bias_reg;
        bias_val[4] = '0;
        bias_val[5] = '0;
        bias_val[6] = baro_bias_reg;
        bias_val[7] = mag_bias_reg;

        amp_val[0] = gps_noise_reg;
        amp_val[1] = gps_noise_reg;
        amp_val[2] = gps_noise_reg;
        amp_val[3] = imu_noise_reg;
        amp_val[4] = imu_noise_reg;
        amp_val[5] = imu_noise_reg;
        amp_val[6] = baro_noise_reg;
        amp_val[7] = mag_noise_reg;

        salt_val[0] = SALT_GPS_X;
        salt_val[1] = SALT_GPS_Y;
        salt_val[2] = SALT_GPS_Z;
        salt_val[3] = SALT_IMU_YAW;
        salt_val[4] = SALT_IMU_PIT;
        salt_val[5] = SALT_IMU_ROLL;
        salt_val[6] = SALT_BARO;
        salt_val[7] = SALT_MAG;
    end

    // stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        en[NUM_STAGES+1] = m_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[1] = en[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // step * golden, split into 32x32 partial products
    always_comb begin
        seed_in    = s_tdata[255:192];
        step_in    = s_tdata[319:256];
        pp_ll_next = {32'd0, step_in[31:0]} * {32'd0, GOLDEN_GAMMA[31:0]};
        pp_lh_next = step_in[31:0] * GOLDEN_GAMMA[63:32];
        pp_hl_next = step_in[63:32] * GOLDEN_GAMMA[31:0];
        mix2_next  = seed1_reg ^ (pp_ll_reg + {pp_lh_reg + pp_hl_reg, 32'd0});
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            seed1_reg <= seed_in;
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            for (int c = 0; c < NUM_CH; c++) begin
                base1_reg[c] <= 33'(true_val[c]) + 33'(bias_val[c]);
            end
        end
        if (en[2]) begin
            mix2_reg <= mix2_next;
            for (int c = 0; c < NUM_CH; c++) begin
                base2_reg[c] <= base1_reg[c];
            end
        end
    end

    assign ch_ctrl.en = en[NUM_STAGES:3];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        sni_channel u_channel (
            .aclk   (aclk),
            .ctrl   (ch_ctrl),
            .mix_in (mix2_reg),
            .salt   (salt_val[c]),
            .base   (base2_reg[c]),
            .amp    (amp_val[c]),
            .result (ch_result[c])
        );
        assign m_tdata[32*c +: 32] = ch_result[c];
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[NUM_STAGES];

endmodule

`default_nettype wire
